FILE: hw/rtl/pgpw_pkg.sv
// ----------------------------------------------------------------------------
// Proportional glyph pixel writer: shared definitions
// Constants, register codes, sequencer states and the request and response
// bundles passed between the sequencer and the coordinate unit.
// ----------------------------------------------------------------------------
package pgpw_pkg;

  localparam int COORD_W  = 8;
  localparam int WIDTH_W  = 3;
  localparam int CFG_IDX_W = 1;

  // glyph ROM geometry: codes from FIRST_CODE, five column bytes per glyph
  localparam logic [COORD_W-1:0] FIRST_CODE = 8'd32;
  localparam int ROM_GLYPHS = 94;
  localparam int ROM_COLS   = 5;
  localparam int ROM_ROW_W  = ROM_COLS * 8;

  localparam int DEF_GLYPH_COUNT   = 94;
  localparam int DEF_GLYPH_COLUMNS = 5;
  localparam int DEF_GLYPH_ROWS    = 7;

  localparam logic [COORD_W-1:0] SCREEN_RESET = 8'd255;

  // configuration register codes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } seq_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] col_off;
    logic [COORD_W-1:0] row_off;
  } pix_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               visible;
  } pix_rsp_t;

endpackage

FILE: hw/rtl/pgpw_if.sv
// ----------------------------------------------------------------------------
// Proportional glyph pixel writer: channel interfaces
// Character request channel and pixel write / width report channel.
// ----------------------------------------------------------------------------
interface pgpw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [7:0] origin_x;
  logic [7:0] origin_y;
  logic       ink;

  modport source (output valid, output char_code, output origin_x, output origin_y,
                  output ink, input ready);
  modport sink   (input valid, input char_code, input origin_x, input origin_y,
                  input ink, output ready);
endinterface

interface pgpw_out_if;
  logic       valid;
  logic       ready;
  logic       is_pixel;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic       pixel_on;
  logic [2:0] glyph_width;
  logic       last;

  modport source (output valid, output is_pixel, output pixel_x, output pixel_y,
                  output pixel_on, output glyph_width, output last, input ready);
  modport sink   (input valid, input is_pixel, input pixel_x, input pixel_y,
                  input pixel_on, input glyph_width, input last, output ready);
endinterface

FILE: hw/rtl/pgpw_rom.sv
// ----------------------------------------------------------------------------
// Glyph ROM
// Registered read of the five column bytes of one glyph, column 0 in the
// top byte. Codes outside the drawable range read as a blank glyph.
// ----------------------------------------------------------------------------
module pgpw_rom
  import pgpw_pkg::*;
#(
  parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [COORD_W-1:0]   char_code,
  output logic [ROM_ROW_W-1:0] glyph_row
);

  localparam int IDX_W = $clog2(ROM_GLYPHS);
  localparam logic [COORD_W-1:0] GLYPH_LIMIT = COORD_W'(GLYPH_COUNT);
  localparam logic [COORD_W-1:0] ROM_LIMIT   = COORD_W'(ROM_GLYPHS);

  localparam logic [ROM_ROW_W-1:0] GLYPH_TABLE [ROM_GLYPHS] = '{
    40'h0000000000, 40'h00005F0000, 40'h0003000300, 40'h147F147F14,
    40'h242A7F2A12, 40'h2616083432, 40'h4A55215000, 40'h0000030000,
    40'h001C224100, 40'h0041221C00, 40'h22147F1422, 40'h08083E0808,
    40'h0000603000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
    40'h3E4141413E, 40'h00427F4000, 40'h4261514946, 40'h2241494936,
    40'h0C0A497F48, 40'h2F49494931, 40'h3E49494932, 40'h0171090503,
    40'h3649494936, 40'h264949493E, 40'h0000363600, 40'h0000563600,
    40'h0814224100, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h3E415D551E, 40'h7E0909097E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141413E, 40'h7F49494941, 40'h7F09090909, 40'h3E4149493A,
    40'h7F0808087F, 40'h00417F4100, 40'h3040413F01, 40'h7F08081463,
    40'h007F404040, 40'h7F0408047F, 40'h7F020C107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151617E, 40'h7F09192946, 40'h2649494932,
    40'h01017F0101, 40'h3F4040403F, 40'h0718601807, 40'h1F6018601F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020000, 40'h304A4A4A7C, 40'h007F444438, 40'h3844444400,
    40'h003844447F, 40'h3854545418, 40'h087E090100, 40'h0C5252523C,
    40'h7F04040478, 40'h00007A0000, 40'h20403A0000, 40'h7F10284400,
    40'h00007F0000, 40'h7C04180478, 40'h0078040478, 40'h3844444438,
    40'h7C14242418, 40'h182424147C, 40'h7C08040400, 40'h4854545424,
    40'h00023F4200, 40'h3C4040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C00, 40'h0836414100,
    40'h00007F0000, 40'h4141360800
  };

  logic [COORD_W-1:0] glyph;
  logic               drawable;

  assign glyph    = char_code - FIRST_CODE;
  assign drawable = (char_code >= FIRST_CODE) && (glyph < GLYPH_LIMIT) && (glyph < ROM_LIMIT);

  always_ff @(posedge clk) begin
    if (load) begin
      glyph_row <= drawable ? GLYPH_TABLE[glyph[IDX_W-1:0]] : '0;
    end
  end

endmodule

FILE: hw/rtl/pgpw_pix.sv
// ----------------------------------------------------------------------------
// Coordinate unit
// Adder and compare pair: origin plus offsets, wrapped to eight bits,
// and the screen clip test.
// ----------------------------------------------------------------------------
module pgpw_pix
  import pgpw_pkg::*;
(
  input  pix_req_t           req,
  input  logic [COORD_W-1:0] screen_width,
  input  logic [COORD_W-1:0] screen_height,
  output pix_rsp_t           rsp
);

  always_comb begin
    rsp.x       = req.origin_x + req.col_off;
    rsp.y       = req.origin_y + req.row_off;
    rsp.visible = (rsp.x < screen_width) && (rsp.y < screen_height);
  end

endmodule

FILE: hw/rtl/pgpw_seq.sv
// ----------------------------------------------------------------------------
// Glyph scan sequencer
// Walks the glyph one bit per cycle, column by column, unless held on a visible pixel;
// counts nonblank columns and loads pixel writes and the width report into the output word.
// ----------------------------------------------------------------------------
module pgpw_seq
  import pgpw_pkg::*;
#(
  parameter int GLYPH_COLUMNS = DEF_GLYPH_COLUMNS,
  parameter int GLYPH_ROWS    = DEF_GLYPH_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  pgpw_in_if.sink              char_in,
  pgpw_out_if.source           pixel_out,
  input  logic [ROM_ROW_W-1:0] glyph_row,
  output pix_req_t             pix_req,
  input  pix_rsp_t             pix_rsp
);

  localparam int COL_W = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
  localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int WID_W = $clog2(GLYPH_COLUMNS + 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);
  localparam logic [WID_W-1:0] WID_MAX  = WID_W'(GLYPH_COLUMNS);

  seq_state_t state, state_next;

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [WID_W-1:0]   wcnt;
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic               ink;

  logic [ROM_ROW_W-1:0] col_shift;
  logic [7:0]           col_byte;
  logic [7:0]           row_shift;
  logic                 bit_set;
  logic [COORD_W-1:0]   wcnt_ext;
  logic [WIDTH_W-1:0]   width_sat;

  logic accept;
  logic out_free;
  logic emit;
  logic advance;
  logic load_pix;
  logic load_rep;

  assign accept   = char_in.valid && char_in.ready;
  assign out_free = !pixel_out.valid || pixel_out.ready;

  // column 0 sits in the top byte; columns past the ROM shift out as blank
  assign col_shift = glyph_row << {col, 3'b000};
  assign col_byte  = col_shift[ROM_ROW_W-1 -: 8];
  assign row_shift = col_byte >> row;
  assign bit_set   = row_shift[0];

  assign wcnt_ext  = COORD_W'(wcnt);
  assign width_sat = (wcnt_ext > 8'd7) ? 3'd7 : wcnt_ext[WIDTH_W-1:0];

  always_comb begin
    pix_req.origin_x = origin_x;
    pix_req.origin_y = origin_y;
    pix_req.col_off  = wcnt_ext;
    pix_req.row_off  = COORD_W'(row);
  end

  assign emit = bit_set && pix_rsp.visible;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance && (row == ROW_LAST) && (col == COL_LAST)) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    char_in.ready = 1'b0;
    advance       = 1'b0;
    load_pix      = 1'b0;
    load_rep      = 1'b0;
    case (state)
      ST_IDLE: begin
        char_in.ready = 1'b1;
      end
      ST_SCAN: begin
        // hold on a visible pixel until the output word is free
        advance  = !emit || out_free;
        load_pix = emit && out_free;
      end
      ST_REPORT: begin
        load_rep = out_free;
      end
      default: begin
        advance = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      origin_x <= char_in.origin_x;
      origin_y <= char_in.origin_y;
      ink      <= char_in.ink;
      col      <= '0;
      row      <= '0;
      wcnt     <= '0;
    end else if (advance) begin
      if (row == ROW_LAST) begin
        row <= '0;
        if (col_byte != 8'd0) begin
          wcnt <= wcnt + 1'b1;
        end
        if (col != COL_LAST) begin
          col <= col + 1'b1;
        end
      end else begin
        row <= row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (load_pix || load_rep) begin
      pixel_out.valid <= 1'b1;
    end else if (pixel_out.ready) begin
      pixel_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pix) begin
      pixel_out.is_pixel    <= 1'b1;
      pixel_out.pixel_x     <= pix_rsp.x;
      pixel_out.pixel_y     <= pix_rsp.y;
      pixel_out.pixel_on    <= ink;
      pixel_out.glyph_width <= '0;
      pixel_out.last        <= 1'b0;
    end else if (load_rep) begin
      pixel_out.is_pixel    <= 1'b0;
      pixel_out.pixel_x     <= '0;
      pixel_out.pixel_y     <= '0;
      pixel_out.pixel_on    <= 1'b0;
      pixel_out.glyph_width <= width_sat;
      pixel_out.last        <= 1'b1;
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && (col == '0) && (row == '0) && (wcnt == '0))
    else $error("scan did not start from the first glyph bit");

  a_width_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (wcnt <= WID_MAX))
    else $error("column count passed the glyph width");

  a_report_then_idle: assert property (@(posedge clk) disable iff (rst)
    load_rep |=> (state == ST_IDLE) && pixel_out.valid && pixel_out.last && !pixel_out.is_pixel)
    else $error("width report not presented on leaving the scan");

  a_no_load_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !load_pix && !load_rep && !advance)
    else $error("output word loaded with no glyph in progress");

endmodule

FILE: hw/rtl/proportional_glyph_pixel_writer_top.sv
// Order: a taken character is registered, its glyph bits are visited in turn and the
// width report is loaded after the last; each pixel word is loaded in the cycle its glyph
// bit is visited. Throughput: one glyph bit is visited per cycle by the scan sequencer,
// held while a visible pixel or the report waits for the output; a new character is
// taken only once the width report is loaded.
// Reset: sequencer idle, no output word pending, screen width and height at 255.
// ----------------------------------------------------------------------------
// Proportional glyph pixel writer
// Draws one 5x7 character as a run of clipped pixel writes followed by a
// width report, packing blank columns out of the glyph.
// ----------------------------------------------------------------------------
module proportional_glyph_pixel_writer_top
  import pgpw_pkg::*;
#(
  parameter int GLYPH_COUNT   = DEF_GLYPH_COUNT,
  parameter int GLYPH_COLUMNS = DEF_GLYPH_COLUMNS,
  parameter int GLYPH_ROWS    = DEF_GLYPH_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  pgpw_in_if.sink              char_in,
  pgpw_out_if.source           pixel_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  logic [COORD_W-1:0]   screen_width;
  logic [COORD_W-1:0]   screen_height;
  logic [ROM_ROW_W-1:0] glyph_row;
  logic                 rom_load;
  pix_req_t             pix_req;
  pix_rsp_t             pix_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_RESET;
      screen_height <= SCREEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
        default: begin
          screen_width <= screen_width;
        end
      endcase
    end
  end

  assign rom_load = char_in.valid && char_in.ready;

  pgpw_rom #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_rom (
    .clk       (clk),
    .load      (rom_load),
    .char_code (char_in.char_code),
    .glyph_row (glyph_row)
  );

  pgpw_pix u_pix (
    .req           (pix_req),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .rsp           (pix_rsp)
  );

  pgpw_seq #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS),
    .GLYPH_ROWS    (GLYPH_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .pixel_out (pixel_out),
    .glyph_row (glyph_row),
    .pix_req   (pix_req),
    .pix_rsp   (pix_rsp)
  );

endmodule
